FILE: rtl/core/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg
// Shared types and character codes for the bracket balance checker.
// ---------------------------------------------------------------------------
package bbc_pkg;

  // Byte codes of the delimiters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_BRACE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  // One classified beat handed from front to back
  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
    logic  open_comment;  // comment still open after the last character
  } tok_t;

endpackage

FILE: rtl/core/bbc_front.sv
// ---------------------------------------------------------------------------
// bbc_front
// Accepts characters, tracks comment skipping, emits stack operations.
// ---------------------------------------------------------------------------
module bbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    char_code,
  input  logic          is_last,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          q_full,
  output logic          q_push,
  output bbc_pkg::tok_t q_tok
);
  import bbc_pkg::*;

  logic in_comment, in_comment_next;
  logic pending_slash, pending_slash_next;
  logic pending_star, pending_star_next;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    in_comment_next    = in_comment;
    pending_slash_next = pending_slash;
    pending_star_next  = pending_star;
    q_tok.op           = OP_NOP;
    q_tok.kind         = KIND_PAREN;
    if (in_comment) begin
      if (pending_star && char_code == CH_SLASH) begin
        in_comment_next   = 1'b0;
        pending_star_next = 1'b0;
      end else begin
        pending_star_next = (char_code == CH_STAR);
      end
    end else if (pending_slash && char_code == CH_STAR) begin
      // this star opens the comment and cannot also close it
      in_comment_next    = 1'b1;
      pending_slash_next = 1'b0;
      pending_star_next  = 1'b0;
    end else begin
      pending_slash_next = (char_code == CH_SLASH);
      case (char_code)
        CH_LPAREN:  begin q_tok.op = OP_PUSH; q_tok.kind = KIND_PAREN;  end
        CH_LSQUARE: begin q_tok.op = OP_PUSH; q_tok.kind = KIND_SQUARE; end
        CH_LBRACE:  begin q_tok.op = OP_PUSH; q_tok.kind = KIND_BRACE;  end
        CH_RPAREN:  begin q_tok.op = OP_POP;  q_tok.kind = KIND_PAREN;  end
        CH_RSQUARE: begin q_tok.op = OP_POP;  q_tok.kind = KIND_SQUARE; end
        CH_RBRACE:  begin q_tok.op = OP_POP;  q_tok.kind = KIND_BRACE;  end
        default: ;
      endcase
    end
    q_tok.last         = is_last;
    q_tok.open_comment = in_comment_next;
  end

  // plain characters never reach the queue unless they end the expression
  assign q_push = accept && (q_tok.op != OP_NOP || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      pending_slash <= 1'b0;
      pending_star  <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        in_comment    <= 1'b0;
        pending_slash <= 1'b0;
        pending_star  <= 1'b0;
      end else begin
        in_comment    <= in_comment_next;
        pending_slash <= pending_slash_next;
        pending_star  <= pending_star_next;
      end
    end
  end

endmodule

FILE: rtl/core/bbc_queue.sv
// ---------------------------------------------------------------------------
// bbc_queue
// Two-entry queue of stack operations between front and back.
// ---------------------------------------------------------------------------
module bbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bbc_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output bbc_pkg::tok_t q_tok
);
  import bbc_pkg::*;

  tok_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bbc_back.sv
// ---------------------------------------------------------------------------
// bbc_back
// Opener stack with cached top and prefetched next entry; result register.
// ---------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bbc_pkg::tok_t q_tok,
  output logic          q_pop,
  output logic          balanced,
  output logic          overflowed,
  output logic          out_valid,
  input  logic          out_stall
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // top of stack lives in a register, entries below it in the memory
  kind_t          mem [STACK_DEPTH];
  kind_t          top, top_next;
  kind_t          below;          // mem[count-2], kept fresh every cycle
  logic [CW-1:0]  count, count_step, count_next;
  logic           mismatch, mismatch_step;
  logic           overflow, overflow_step;
  logic           fire, out_free, finish;
  logic           we, fwd;
  logic [AW-1:0]  waddr, raddr;
  logic [CW-1:0]  cnt_m1, cnt_m2;

  assign out_free = !out_valid || !out_stall;
  assign fire     = q_valid && (!q_tok.last || out_free);
  assign q_pop    = fire;
  assign finish   = fire && q_tok.last;

  assign cnt_m1 = count - CW'(1);
  assign waddr  = cnt_m1[AW-1:0];

  always_comb begin
    count_step    = count;
    mismatch_step = mismatch;
    overflow_step = overflow;
    top_next      = top;
    we            = 1'b0;
    if (fire) begin
      case (q_tok.op)
        OP_PUSH: begin
          if (count == CW'(STACK_DEPTH)) begin
            overflow_step = 1'b1;
          end else begin
            we         = (count != '0);
            top_next   = q_tok.kind;
            count_step = count + CW'(1);
          end
        end
        OP_POP: begin
          if (count == '0 || top != q_tok.kind) begin
            mismatch_step = 1'b1;
          end else begin
            top_next   = below;
            count_step = cnt_m1;
          end
        end
        default: ;
      endcase
    end
    count_next = finish ? '0 : count_step;
  end

  assign cnt_m2 = count_next - CW'(2);
  assign raddr  = cnt_m2[AW-1:0];
  assign fwd    = we && (raddr == waddr);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= top;
    if (fwd) below <= top;
    else     below <= mem[raddr];
    top <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      mismatch <= finish ? 1'b0 : mismatch_step;
      overflow <= finish ? 1'b0 : overflow_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      balanced   <= !mismatch_step && count_step == '0 && !q_tok.open_comment &&
                    !overflow_step;
      overflowed <= overflow_step;
    end
  end

endmodule

FILE: rtl/core/bracket_balance_checker_core.sv
// ---------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks (), [] and {} nesting over a character stream, skipping comments.
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   in      | in_valid / in_stall  | char_code[7:0], is_last
//   out     | out_valid / out_stall| balanced, overflowed
//
// One character beat per cycle sustained. The front tracks comment state and
// turns each character into a push, a pop or nothing in the cycle it is
// taken; a two-entry queue hands operations to the back, which does one
// stack operation per cycle against a cached top register and a prefetched
// second entry from the stack memory. The last character reaches the result
// beat through the queue and the result register. Reset clears all control
// state; the stack memory needs no clearing. in_stall rises only when the
// queue is full, which happens when out_stall holds back a finished result.
// ---------------------------------------------------------------------------
module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       is_last,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       balanced,
  output logic       overflowed,
  output logic       out_valid,
  input  logic       out_stall
);
  import bbc_pkg::*;

  // front -> queue
  logic q_push, q_full;
  tok_t push_tok;
  // queue -> back
  logic q_valid, q_pop;
  tok_t q_tok;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .is_last   (is_last),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .q_pop      (q_pop),
    .balanced   (balanced),
    .overflowed (overflowed),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
